/* sv/srpat_pkg.sv */
package srpat_pkg;

    localparam int unsigned DW = 32;
    localparam int unsigned FW = 16;

    localparam logic [31:0] ONE_Q  = 32'h0001_0000;
    localparam logic [31:0] C_1P2  = 32'd78643;
    localparam logic [31:0] MAX_Q  = 32'h7fff_ffff;
    localparam logic [31:0] MIN_Q  = 32'h8000_0000;

    localparam logic [1:0] MIN_SAMPLES = 2'd3;

    localparam logic [7:0] CFG_STEP_SIZE = 8'd0;
    localparam logic [7:0] CFG_INIT_VAL  = 8'd1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FEW      = 3'd1;
    localparam logic [2:0] ST_NO_SLOPE = 3'd2;
    localparam logic [2:0] ST_ZERO_KL  = 3'd3;
    localparam logic [2:0] ST_BAD_TIME = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOPE,
        S_SHIFT,
        S_CHECK,
        S_K,
        S_L,
        S_TPL,
        S_TAU,
        S_KL,
        S_NUM,
        S_KP,
        S_KI,
        S_KD,
        S_OUT
    } seq_state_t;

endpackage

/* sv/step_response_pid_autotuner_top.sv */
// Sequencing: once two samples are held, each new sample with a valid time runs a restoring
// divide for the slope; the last sample of a record then runs up to five divides and three
// multiplies on the shared divider and multiplier before m_tvalid rises.
// Throughput: one sample at a time; s_tready is low while the sequencer runs. A finished
// result waits in the output register while the next record is accepted.
// Reset: synchronous active-low aresetn clears the record, the sequencer and the output valid,
// and sets step_size to 1.0 and initial_value to 0.
module step_response_pid_autotuner_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // sample_time[31:0], sample_value[63:32]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // process_gain[31:0], dead_time[62:32], time_constant[93:63], prop_gain[125:94],
    // int_gain[157:126], deriv_gain[189:158], zero[191:190]
    output logic [191:0] m_tdata,
    output logic [2:0]   m_tuser,   // status[2:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    srpat_pkg::seq_state_t state_reg, state_next;

    logic signed [31:0] step_reg, init_reg;
    logic [31:0]        samp_time_reg;
    logic signed [31:0] samp_val_reg;
    logic               last_reg;
    logic [31:0]        older_time_reg, newer_time_reg, knee_time_reg;
    logic signed [31:0] older_val_reg, newer_val_reg, knee_val_reg, best_reg;
    logic [1:0]         count_reg;
    logic               terr_reg;

    logic signed [31:0] k_reg, l_reg, tpl_reg, tau_reg, kl_reg, num_reg;
    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [2:0]         status_reg;

    logic               phase_reg;
    logic [32:0]        div_rem_reg;
    logic [48:0]        div_num_reg;
    logic [32:0]        div_den_reg;
    logic [5:0]         div_cnt_reg;
    logic               div_neg_reg;
    logic [63:0]        mul_reg;
    logic               mul_neg_reg;

    logic               m_valid_reg;
    logic [191:0]       m_data_reg;
    logic [2:0]         m_user_reg;

    logic               s_acc, terr_in, is_div, is_mul, skip, launch, fin, out_load;
    logic signed [33:0] op_a, op_b;
    logic [33:0]        mag_a34, mag_b34;
    logic [31:0]        mmag_a, mmag_b;
    logic signed [31:0] res;
    logic [33:0]        rem_sh;
    logic               rem_ge;
    logic signed [33:0] l_diff, tpl_sum, tau_diff;
    logic signed [31:0] l_clamp, tau_clamp;

    function automatic logic signed [31:0] sat_q(input logic [48:0] m, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (m >= 49'h0_8000_0000) r = srpat_pkg::MIN_Q;
            else r = -$signed(m[31:0]);
        end else begin
            if (m > 49'h0_7fff_ffff) r = srpat_pkg::MAX_Q;
            else r = $signed(m[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp34(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sh0_7fff_ffff) r = srpat_pkg::MAX_Q;
        else if (x < -34'sh0_8000_0000) r = srpat_pkg::MIN_Q;
        else r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] half(input logic signed [31:0] x);
        logic signed [32:0] s;
        s = {x[31], x} + {32'd0, x[31]};
        return s[32:1];
    endfunction

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign terr_in   = terr_reg || (count_reg != 2'd0 && s_tdata[31:0] <= newer_time_reg);

    // operand select for the shared divider and multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            srpat_pkg::S_SLOPE: begin
                op_a = 34'(samp_val_reg) - 34'(older_val_reg);
                op_b = $signed({2'b00, samp_time_reg}) - $signed({2'b00, older_time_reg});
            end
            srpat_pkg::S_K: begin
                op_a = 34'(samp_val_reg) - 34'(init_reg);
                op_b = 34'(step_reg);
            end
            srpat_pkg::S_L: begin
                op_a = 34'(knee_val_reg) - 34'(init_reg);
                op_b = 34'(best_reg);
            end
            srpat_pkg::S_TPL: begin
                op_a = 34'(samp_val_reg) - 34'(knee_val_reg);
                op_b = 34'(best_reg);
            end
            srpat_pkg::S_KL: begin
                op_a = 34'(k_reg);
                op_b = 34'(l_reg);
            end
            srpat_pkg::S_NUM: begin
                op_a = 34'(tau_reg);
                op_b = 34'($signed(srpat_pkg::C_1P2));
            end
            srpat_pkg::S_KP: begin
                op_a = 34'(num_reg);
                op_b = 34'(kl_reg);
            end
            srpat_pkg::S_KI, srpat_pkg::S_KD: begin
                op_a = 34'(kp_reg);
                op_b = 34'(l_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mag_a34 = op_a[33] ? 34'(-op_a) : 34'(op_a);
    assign mag_b34 = op_b[33] ? 34'(-op_b) : 34'(op_b);
    assign mmag_a  = op_a[31] ? 32'(-op_a[31:0]) : op_a[31:0];
    assign mmag_b  = op_b[31] ? 32'(-op_b[31:0]) : op_b[31:0];

    assign rem_sh = {div_rem_reg, div_num_reg[48]};
    assign rem_ge = rem_sh >= {1'b0, div_den_reg};

    assign res = is_mul ? sat_q({1'b0, mul_reg[63:16]}, mul_neg_reg)
                        : sat_q(div_num_reg, div_neg_reg);

    assign l_diff   = $signed({2'b00, knee_time_reg}) - 34'(res);
    assign l_clamp  = clamp34(l_diff);
    assign tpl_sum  = $signed({2'b00, knee_time_reg}) + 34'(res);
    assign tau_diff = 34'(tpl_reg) - 34'(l_reg);
    assign tau_clamp = clamp34(tau_diff);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srpat_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (count_reg >= 2'd2 && !terr_in) state_next = srpat_pkg::S_SLOPE;
                    else state_next = srpat_pkg::S_SHIFT;
                end
            end
            srpat_pkg::S_SLOPE: if (fin) state_next = srpat_pkg::S_SHIFT;
            srpat_pkg::S_SHIFT: begin
                state_next = last_reg ? srpat_pkg::S_CHECK : srpat_pkg::S_IDLE;
            end
            srpat_pkg::S_CHECK: begin
                if (count_reg < srpat_pkg::MIN_SAMPLES || terr_reg || best_reg <= 0)
                    state_next = srpat_pkg::S_OUT;
                else
                    state_next = srpat_pkg::S_K;
            end
            srpat_pkg::S_K:   if (skip || fin) state_next = srpat_pkg::S_L;
            srpat_pkg::S_L:   if (fin) state_next = srpat_pkg::S_TPL;
            srpat_pkg::S_TPL: if (fin) state_next = srpat_pkg::S_TAU;
            srpat_pkg::S_TAU: begin
                state_next = (k_reg == 0 || l_reg == 0) ? srpat_pkg::S_OUT : srpat_pkg::S_KL;
            end
            srpat_pkg::S_KL:  if (fin) state_next = srpat_pkg::S_NUM;
            srpat_pkg::S_NUM: if (fin) state_next = srpat_pkg::S_KP;
            srpat_pkg::S_KP:  if (skip || fin) state_next = srpat_pkg::S_KI;
            srpat_pkg::S_KI:  if (fin) state_next = srpat_pkg::S_KD;
            srpat_pkg::S_KD:  if (fin) state_next = srpat_pkg::S_OUT;
            srpat_pkg::S_OUT: if (out_load) state_next = srpat_pkg::S_IDLE;
            default:          state_next = srpat_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        is_div   = 1'b0;
        is_mul   = 1'b0;
        skip     = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            srpat_pkg::S_IDLE: s_tready = 1'b1;
            srpat_pkg::S_SLOPE, srpat_pkg::S_L, srpat_pkg::S_TPL, srpat_pkg::S_KI: is_div = 1'b1;
            srpat_pkg::S_K: begin
                is_div = 1'b1;
                skip   = (step_reg == 0);
            end
            srpat_pkg::S_KP: begin
                is_div = 1'b1;
                skip   = (kl_reg == 0);
            end
            srpat_pkg::S_KL, srpat_pkg::S_NUM, srpat_pkg::S_KD: is_mul = 1'b1;
            // hold the finished result until the output register is free
            srpat_pkg::S_OUT: out_load = !m_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign launch = !phase_reg && (is_div || is_mul) && !skip;
    assign fin    = phase_reg && (is_mul || (is_div && div_cnt_reg == 6'd0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srpat_pkg::S_IDLE;
            step_reg    <= srpat_pkg::ONE_Q;
            init_reg    <= '0;
            phase_reg   <= 1'b0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            older_time_reg <= '0;
            older_val_reg  <= '0;
            newer_time_reg <= '0;
            newer_val_reg  <= '0;
            count_reg      <= '0;
            best_reg       <= '0;
            knee_time_reg  <= '0;
            knee_val_reg   <= '0;
            terr_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                if (cfg_index == srpat_pkg::CFG_STEP_SIZE) step_reg <= cfg_data;
                else if (cfg_index == srpat_pkg::CFG_INIT_VAL) init_reg <= cfg_data;
            end

            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;

            if (launch) phase_reg <= 1'b1;
            else if (fin) phase_reg <= 1'b0;

            // shared restoring divider, one quotient bit per cycle
            if (launch && is_div) begin
                div_rem_reg <= '0;
                div_num_reg <= {mag_a34[32:0], 16'd0};
                div_den_reg <= mag_b34[32:0];
                div_cnt_reg <= 6'd49;
                div_neg_reg <= op_a[33] ^ op_b[33];
            end else if (div_cnt_reg != 6'd0) begin
                div_rem_reg <= rem_ge ? 33'(rem_sh - {1'b0, div_den_reg}) : rem_sh[32:0];
                div_num_reg <= {div_num_reg[47:0], rem_ge};
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end

            if (launch && is_mul) begin
                mul_reg     <= mmag_a * mmag_b;
                mul_neg_reg <= op_a[31] ^ op_b[31];
            end

            case (state_reg)
                srpat_pkg::S_IDLE: begin
                    if (s_acc) begin
                        samp_time_reg <= s_tdata[31:0];
                        samp_val_reg  <= s_tdata[63:32];
                        last_reg      <= s_tlast;
                        terr_reg      <= terr_in;
                    end
                end
                srpat_pkg::S_SLOPE: begin
                    if (fin && res > best_reg) begin
                        best_reg      <= res;
                        knee_time_reg <= newer_time_reg;
                        knee_val_reg  <= newer_val_reg;
                    end
                end
                srpat_pkg::S_SHIFT: begin
                    older_time_reg <= newer_time_reg;
                    older_val_reg  <= newer_val_reg;
                    newer_time_reg <= samp_time_reg;
                    newer_val_reg  <= samp_val_reg;
                    if (count_reg < srpat_pkg::MIN_SAMPLES) count_reg <= count_reg + 2'd1;
                end
                srpat_pkg::S_CHECK: begin
                    k_reg  <= '0;
                    l_reg  <= '0;
                    tau_reg <= '0;
                    kp_reg <= '0;
                    ki_reg <= '0;
                    kd_reg <= '0;
                    if (count_reg < srpat_pkg::MIN_SAMPLES) status_reg <= srpat_pkg::ST_FEW;
                    else if (terr_reg) status_reg <= srpat_pkg::ST_BAD_TIME;
                    else if (best_reg <= 0) status_reg <= srpat_pkg::ST_NO_SLOPE;
                    else status_reg <= srpat_pkg::ST_OK;
                end
                srpat_pkg::S_K:   if (fin) k_reg <= res;
                srpat_pkg::S_L:   if (fin) l_reg <= l_clamp[31] ? 32'sd0 : l_clamp;
                srpat_pkg::S_TPL: if (fin) tpl_reg <= clamp34(tpl_sum);
                srpat_pkg::S_TAU: begin
                    tau_reg <= (tau_clamp <= 0) ? srpat_pkg::ONE_Q : tau_clamp;
                    if (k_reg == 0 || l_reg == 0) status_reg <= srpat_pkg::ST_ZERO_KL;
                end
                srpat_pkg::S_KL:  if (fin) kl_reg <= res;
                srpat_pkg::S_NUM: if (fin) num_reg <= res;
                srpat_pkg::S_KP: begin
                    if (skip) kp_reg <= k_reg[31] ? srpat_pkg::MIN_Q : srpat_pkg::MAX_Q;
                    else if (fin) kp_reg <= res;
                end
                srpat_pkg::S_KI:  if (fin) ki_reg <= half(res);
                srpat_pkg::S_KD:  if (fin) kd_reg <= half(res);
                srpat_pkg::S_OUT: begin
                    if (out_load) begin
                        m_user_reg  <= status_reg;
                        m_data_reg  <= {2'b00, kd_reg, ki_reg, kp_reg, tau_reg[30:0],
                                        l_reg[30:0], k_reg};
                        // start a fresh record
                        older_time_reg <= '0;
                        older_val_reg  <= '0;
                        newer_time_reg <= '0;
                        newer_val_reg  <= '0;
                        count_reg      <= '0;
                        best_reg       <= '0;
                        knee_time_reg  <= '0;
                        knee_val_reg   <= '0;
                        terr_reg       <= 1'b0;
                    end
                end
                default: begin
                    terr_reg <= terr_reg;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == srpat_pkg::S_OUT))
        else $error("result valid without finishing step");

    a_div_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cnt_reg != 6'd0) |-> (state_reg != srpat_pkg::S_IDLE))
        else $error("divider running while idle");

    a_terr_has_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (terr_reg && state_reg == srpat_pkg::S_IDLE) |-> (count_reg != 2'd0))
        else $error("time error with empty record");
`endif

endmodule
